>>> hdl/pmc_pkg.sv
// Package: shared types and constants for the PS/2 mouse packet cursor block.
`default_nettype none
package pmc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned COLOUR_W    = 2;
  localparam int unsigned BUTTONS     = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned NUM_COLOURS_DEF = 4;

  localparam logic [POS_W-1:0] X_MAX_RESET = POS_W'(310);
  localparam logic [POS_W-1:0] Y_MAX_RESET = POS_W'(190);
  localparam logic [POS_W-1:0] X_START     = POS_W'(155);
  localparam logic [POS_W-1:0] Y_START     = POS_W'(95);

  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_e;

  typedef struct packed {
    logic [BUTTONS-1:0] buttons;
    logic [BYTE_W-1:0]  dx;
    logic [BYTE_W-1:0]  dy;
  } packet_t;

  typedef struct packed {
    logic [POS_W-1:0] x_max;
    logic [POS_W-1:0] y_max;
  } cfg_t;

endpackage
`default_nettype wire

>>> hdl/pmc_front.sv
// Front end: assembles mouse bytes into 3-byte packets and pushes them to the queue.
`default_nettype none
module pmc_front import pmc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic              from_mouse_i,
  input  wire logic              q_ready_i,
  output logic                   q_push_o,
  output packet_t                q_pkt_o
);

  logic [1:0]        byte_pos_q, byte_pos_d;
  logic [BYTE_W-1:0] byte0_q, byte1_q;
  logic              xfer;

  assign in_ready_o = q_ready_i;
  assign xfer       = in_valid_i && q_ready_i && from_mouse_i;
  assign q_push_o   = xfer && (byte_pos_q == 2'd2);

  assign q_pkt_o.buttons = byte0_q[BUTTONS-1:0];
  assign q_pkt_o.dx      = byte1_q;
  assign q_pkt_o.dy      = data_byte_i;

  always_comb begin
    byte_pos_d = byte_pos_q;
    if (xfer) begin
      byte_pos_d = (byte_pos_q == 2'd2) ? 2'd0 : byte_pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= 2'd0;
    end else begin
      byte_pos_q <= byte_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer && byte_pos_q == 2'd0) begin
      byte0_q <= data_byte_i;
    end
    if (xfer && byte_pos_q == 2'd1) begin
      byte1_q <= data_byte_i;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pmc_queue.sv
// Packet queue between the front end and the event sequencer.
`default_nettype none
module pmc_queue import pmc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  packet_t   pkt_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output packet_t   pkt_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  packet_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign pkt_o   = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= pkt_i;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pmc_back.sv
// Back end: steps through a packet's events, updates cursor and colour, holds the output register.
`default_nettype none
module pmc_back import pmc_pkg::*; #(
  parameter int unsigned NUM_COLOURS = NUM_COLOURS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  cfg_t                     cfg_i,
  input  wire logic                pkt_valid_i,
  input  packet_t                  pkt_i,
  output logic                     pkt_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               event_kind_o,
  output logic [1:0]               button_number_o,
  output logic signed [BYTE_W-1:0] delta_x_o,
  output logic signed [BYTE_W-1:0] delta_y_o,
  output logic [POS_W-1:0]         cursor_x_o,
  output logic [POS_W-1:0]         cursor_y_o,
  output logic [COLOUR_W-1:0]      colour_index_o,
  output logic                     last_of_run_o
);

  localparam int unsigned SUM_W = POS_W + 2;

  // pending bit 0: move, bits 1..3: buttons 1..3
  logic [BUTTONS:0]     pend_q, pend_d, sel;
  logic [BUTTONS-1:0]   btn_now_q, btn_state_q;
  logic [BYTE_W-1:0]    dx_q, dy_q;
  logic [POS_W-1:0]     pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic [COLOUR_W-1:0]  colour_q, colour_d;
  logic                 active, emit, last, load;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [1:0]           btn_num;
  ev_kind_e             kind;

  logic                 ov_q;
  ev_kind_e             kind_q;
  logic [1:0]           btn_q;
  logic [BYTE_W-1:0]    odx_q, ody_q;
  logic                 last_q;

  assign active    = (pend_q != '0);
  assign emit      = active && (!ov_q || out_ready_i);
  assign last      = ((pend_q & ~sel) == '0);
  assign load      = pkt_valid_i && (!active || (emit && last));
  assign pkt_pop_o = load;

  always_comb begin
    sel     = '0;
    btn_num = 2'd0;
    priority if (pend_q[0]) begin
      sel[0] = 1'b1;
    end else if (pend_q[1]) begin
      sel[1]  = 1'b1;
      btn_num = 2'd1;
    end else if (pend_q[2]) begin
      sel[2]  = 1'b1;
      btn_num = 2'd2;
    end else if (pend_q[3]) begin
      sel[3]  = 1'b1;
      btn_num = 2'd3;
    end else begin
      btn_num = 2'd0;
    end
  end

  assign sum_x = SUM_W'(signed'({2'b00, pos_x_q})) + SUM_W'(signed'(dx_q));
  assign sum_y = SUM_W'(signed'({2'b00, pos_y_q})) - SUM_W'(signed'(dy_q));

  always_comb begin
    pend_d   = pend_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    colour_d = colour_q;
    kind     = EV_MOVE;
    if (emit) begin
      pend_d = pend_q & ~sel;
      if (sel[0]) begin
        if (sum_x[SUM_W-1]) pos_x_d = '0;
        else if (sum_x[SUM_W-2:0] > {1'b0, cfg_i.x_max}) pos_x_d = cfg_i.x_max;
        else pos_x_d = sum_x[POS_W-1:0];
        if (sum_y[SUM_W-1]) pos_y_d = '0;
        else if (sum_y[SUM_W-2:0] > {1'b0, cfg_i.y_max}) pos_y_d = cfg_i.y_max;
        else pos_y_d = sum_y[POS_W-1:0];
      end else if (btn_now_q[btn_num - 2'd1]) begin
        kind = EV_PRESS;
        colour_d = (colour_q >= COLOUR_W'(NUM_COLOURS - 1)) ? '0 : colour_q + COLOUR_W'(1);
      end else begin
        kind = EV_RELEASE;
      end
    end
    if (load) begin
      pend_d = {pkt_i.buttons ^ btn_state_q, (pkt_i.dx != '0) || (pkt_i.dy != '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      btn_state_q <= '0;
      pos_x_q     <= X_START;
      pos_y_q     <= Y_START;
      colour_q    <= '0;
      ov_q        <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      colour_q <= colour_d;
      if (load) btn_state_q <= pkt_i.buttons;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      btn_now_q <= pkt_i.buttons;
      dx_q      <= pkt_i.dx;
      dy_q      <= pkt_i.dy;
    end
    if (emit) begin
      kind_q <= kind;
      btn_q  <= btn_num;
      odx_q  <= sel[0] ? dx_q : '0;
      ody_q  <= sel[0] ? dy_q : '0;
      last_q <= last;
    end
  end

  assign out_valid_o     = ov_q;
  assign event_kind_o    = kind_q;
  assign button_number_o = btn_q;
  assign delta_x_o       = signed'(odx_q);
  assign delta_y_o       = signed'(ody_q);
  assign cursor_x_o      = pos_x_q;
  assign cursor_y_o      = pos_y_q;
  assign colour_index_o  = colour_q;
  assign last_of_run_o   = last_q;

endmodule
`default_nettype wire

>>> hdl/ps2_mouse_packet_cursor.sv
// Top level: PS/2 mouse packet decoder driving a clamped cursor and a colour cycle.
// Throughput: one byte per cycle while the packet queue has room; a packet yields
//   up to four events, one per cycle unless stalled, set by the back end's event sequencer.
// Path: a packet's first event goes through the queue, pend_q and the output register.
// Reset (async, active low): cursor 155/95, limits 310/190, buttons and colour zero,
//   queue and output register empty.
`default_nettype none
module ps2_mouse_packet_cursor import pmc_pkg::*; #(
  parameter int unsigned NUM_COLOURS = NUM_COLOURS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [POS_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    data_byte_i,
  input  wire logic                 from_mouse_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [1:0]                event_kind_o,
  output logic [1:0]                button_number_o,
  output logic signed [BYTE_W-1:0]  delta_x_o,
  output logic signed [BYTE_W-1:0]  delta_y_o,
  output logic [POS_W-1:0]          cursor_x_o,
  output logic [POS_W-1:0]          cursor_y_o,
  output logic [COLOUR_W-1:0]       colour_index_o,
  output logic                      last_of_run_o
);

  cfg_t    cfg_q;
  packet_t push_pkt, pop_pkt;
  logic    q_ready, q_push, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_max <= X_MAX_RESET;
      cfg_q.y_max <= Y_MAX_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_X_MAX) cfg_q.x_max <= cfg_data_i;
      if (cfg_idx_i == REG_Y_MAX) cfg_q.y_max <= cfg_data_i;
    end
  end

  pmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .from_mouse_i (from_mouse_i),
    .q_ready_i    (q_ready),
    .q_push_o     (q_push),
    .q_pkt_o      (push_pkt)
  );

  pmc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pkt_i   (push_pkt),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .pkt_o   (pop_pkt)
  );

  pmc_back #(
    .NUM_COLOURS (NUM_COLOURS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .pkt_valid_i     (q_valid),
    .pkt_i           (pop_pkt),
    .pkt_pop_o       (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .button_number_o (button_number_o),
    .delta_x_o       (delta_x_o),
    .delta_y_o       (delta_y_o),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .colour_index_o  (colour_index_o),
    .last_of_run_o   (last_of_run_o)
  );

  a_move_no_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_MOVE |-> button_number_o == 2'd0)
    else $error("move event carries a button number");

  a_button_no_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != EV_MOVE |->
      button_number_o != 2'd0 && delta_x_o == '0 && delta_y_o == '0)
    else $error("button event malformed");

  a_colour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(colour_index_o) < NUM_COLOURS)
    else $error("colour index out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("packet pushed into full queue");

endmodule
`default_nettype wire
